>>> rtl/core/ecgd_pkg.sv
package ecgd_pkg;

    localparam logic [7:0] HEADER_BYTE  = 8'hAA;
    localparam logic [7:0] TRAILER_BYTE = 8'hEF;

    // Result kinds as they appear on result_kind.
    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_COMMIT  = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [7:0]  index;
        logic [7:0]  count;
    } result_t;

endpackage

>>> rtl/core/ecgd_in_stage.sv
module ecgd_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       byte_valid,
    output logic [7:0] byte_data,
    input  logic       byte_take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // The register refills in the same cycle that the parser drains it.
    assign in_ready   = !valid_reg || byte_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !byte_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

>>> rtl/core/ecgd_parser.sv
module ecgd_parser
    import ecgd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    input  logic       res_ready,
    output logic       byte_take,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LENGTH = 3'd1,
        PH_HIGH   = 3'd2,
        PH_LOW    = 3'd3,
        PH_END    = 3'd4
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] length_reg;
    logic [7:0] length_next;
    logic [7:0] seen_reg;
    logic [7:0] seen_next;
    logic [7:0] high_reg;
    logic [7:0] high_next;
    logic       emit;

    assign byte_take = byte_valid && res_ready;

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        seen_next   = seen_reg;
        high_next   = high_reg;
        emit        = 1'b0;
        res         = '0;
        unique case (phase_reg)
            PH_LENGTH:
            begin
                length_next = byte_data;
                seen_next   = 8'd0;
                phase_next  = PH_HIGH;
            end
            PH_HIGH:
            begin
                high_next  = byte_data;
                phase_next = PH_LOW;
            end
            PH_LOW:
            begin
                // A zero length ends the frame after one sample, like a length of one.
                seen_next  = seen_reg + 8'd1;
                phase_next = (seen_next >= length_reg) ? PH_END : PH_HIGH;
                emit       = 1'b1;
                res.kind   = KIND_SAMPLE;
                res.value  = {high_reg, byte_data};
                res.index  = seen_reg;
            end
            PH_END:
            begin
                // The trailer slot is never taken as a new header.
                phase_next = PH_IDLE;
                emit       = 1'b1;
                res.kind   = (byte_data == TRAILER_BYTE) ? KIND_COMMIT : KIND_DISCARD;
                res.count  = seen_reg;
            end
            default:
            begin
                phase_next = (byte_data == HEADER_BYTE) ? PH_LENGTH : PH_IDLE;
            end
        endcase
    end

    assign res_valid = byte_take && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            length_reg <= 8'd0;
            seen_reg   <= 8'd0;
            high_reg   <= 8'd0;
        end
        else if (byte_take)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            seen_reg   <= seen_next;
            high_reg   <= high_next;
        end
    end

endmodule

>>> rtl/core/ecgd_out_stage.sv
module ecgd_out_stage
    import ecgd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  result_t res,
    output logic    res_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign res_ready  = !valid_reg || out_ready;
    assign valid_next = res_valid || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

>>> rtl/core/ecg_frame_deframer.sv
// ECG frame deframer. Each input beat carries one received serial byte. The
// block looks for the header byte 0xAA, takes the next byte as the sample
// count, then assembles big-endian 16-bit samples (high byte first) until that
// count is reached; a count of zero still reads one sample. Every finished
// sample leaves at once as a provisional result (result_kind 0) with its index
// in the frame. The byte after the last sample is the trailer slot: 0xEF gives
// a commit result (kind 1), any other byte a discard result (kind 2), both with
// the number of samples in frame_count, and the downstream side keeps or drops
// the provisional samples accordingly. Bytes outside a frame that are not a
// header are dropped, and a header byte inside a frame is plain data. The
// block takes one byte per clock cycle when the output side keeps up: a byte
// passes from the input register through the parser's next-state logic into
// the result register, and the only stall comes from a full result register
// that is not being taken.
module ecg_frame_deframer
    import ecgd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [15:0] sample_value,
    output logic [7:0]  sample_index,
    output logic [7:0]  frame_count
);

    logic    byte_valid;
    logic [7:0] byte_data;
    logic    byte_take;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t out_res;

    ecgd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take)
    );

    ecgd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .res_ready  (res_ready),
        .byte_take  (byte_take),
        .res_valid  (res_valid),
        .res        (res)
    );

    ecgd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign result_kind  = out_res.kind;
    assign sample_value = out_res.value;
    assign sample_index = out_res.index;
    assign frame_count  = out_res.count;

    // A sample result never carries a count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_SAMPLE |-> frame_count == 8'd0)
        else $error("sample beat with nonzero frame_count");

    // End results carry neither a sample value nor an index.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_COMMIT || result_kind == KIND_DISCARD)
        |-> sample_value == 16'd0 && sample_index == 8'd0)
        else $error("end beat with sample payload");

    // The parser only produces a result when it also consumes a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> byte_take && byte_valid)
        else $error("result without a consumed byte");

    // An empty input register always accepts a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !byte_valid |-> in_ready)
        else $error("input stalled while input register is empty");

endmodule
